[hw/rtl/deadline_task_table_assert.svh]
// ----------------------------------------------------------------------------
// Deadline task table assertion macros
// Implication and invariant checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TASK_TABLE_ASSERT_SVH
`define DEADLINE_TASK_TABLE_ASSERT_SVH

`ifndef SYNTH

`define DTT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define DTT_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

`else

`define DTT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`define DTT_ASSERT_ALWAYS(label, clk, rst, expr, msg)

`endif

`endif

[hw/rtl/dtt_pkg.sv]
// ----------------------------------------------------------------------------
// Deadline task table package
// Codes, widths and the command and status groups shared by the modules.
// ----------------------------------------------------------------------------
package dtt_pkg;

   localparam int TIME_W      = 48;
   localparam int TAG_W       = 8;
   localparam int MAX_RESULTS = 16;
   localparam int RES_CW      = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] KIND_POST = 2'd0;
   localparam logic [1:0] KIND_TICK = 2'd1;
   localparam logic [1:0] KIND_STOP = 2'd2;

   localparam logic [1:0] RES_ACCEPTED = 2'd0;
   localparam logic [1:0] RES_REJECTED = 2'd1;
   localparam logic [1:0] RES_DUE      = 2'd2;
   localparam logic [1:0] RES_FLUSHED  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic post;
      logic start;
      logic read;
      logic eval;
      logic final_push;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic due;
      logic pend_valid;
      logic out_free;
   } stat_type;

endpackage

[hw/rtl/dtt_ctrl.sv]
// ----------------------------------------------------------------------------
// Deadline task table controller
// Sequences posts and the entry by entry scan of ticks and stops.
// ----------------------------------------------------------------------------
module dtt_ctrl import dtt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_kind,
   output logic       req_stall,
   input  stat_type   stat,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = !stat.out_free;
            if (req_valid && stat.out_free) begin
               if (req_kind == KIND_POST) begin
                  cmd.post = 1'b1;
               end else if (req_kind == KIND_TICK || req_kind == KIND_STOP) begin
                  cmd.start = 1'b1;
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            if (stat.scan_done) begin
               state_in = ST_FINAL;
            end else begin
               cmd.read = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!(stat.due && stat.pend_valid && !stat.out_free)) begin
               cmd.eval = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_FINAL: begin
            if (!(stat.pend_valid && !stat.out_free)) begin
               cmd.final_push = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[hw/rtl/dtt_dp.sv]
// ----------------------------------------------------------------------------
// Deadline task table datapath
// Entry memories, scan counters, held result and the output register.
// ----------------------------------------------------------------------------
module dtt_dp import dtt_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        req_kind,
   input  logic [TIME_W-1:0] req_now_ms,
   input  logic [TIME_W-1:0] req_delay_ms,
   input  logic [TAG_W-1:0]  req_task_tag,
   input  logic              rsp_stall,
   input  cmd_type           cmd,
   output stat_type          stat,
   output logic              rsp_valid,
   output logic [1:0]        rsp_result_kind,
   output logic [TAG_W-1:0]  rsp_task_tag_res,
   output logic              rsp_last
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [TIME_W-1:0] dl_mem [DEPTH];
   logic [TAG_W-1:0]  tag_mem [DEPTH];

   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     keep_ff, keep_in;
   logic [RES_CW-1:0] nres_ff, nres_in;
   logic              is_tick_ff, is_tick_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] rd_dl_ff;
   logic [TAG_W-1:0]  rd_tag_ff;
   logic [TAG_W-1:0]  pend_tag_ff, pend_tag_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic [TAG_W-1:0]  rsp_tag_ff, rsp_tag_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [TIME_W:0]   sum;
   logic [TIME_W-1:0] post_dl;
   logic              full;
   logic              due;
   logic              out_free;
   logic              we;
   logic [AW-1:0]     wa;
   logic [TIME_W-1:0] wd_dl;
   logic [TAG_W-1:0]  wd_tag;
   logic              push;
   logic [1:0]        push_kind;
   logic [TAG_W-1:0]  push_tag;
   logic              push_last;

   assign sum      = {1'b0, req_now_ms} + {1'b0, req_delay_ms};
   assign post_dl  = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
   assign full     = count_ff >= CW'(DEPTH);
   assign due      = (!is_tick_ff || rd_dl_ff <= now_ff) &&
                     (nres_ff < RES_CW'(MAX_RESULTS));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      keep_in       = keep_ff;
      nres_in       = nres_ff;
      is_tick_in    = is_tick_ff;
      now_in        = now_ff;
      pend_tag_in   = pend_tag_ff;
      pend_valid_in = pend_valid_ff;
      we            = 1'b0;
      wa            = keep_ff[AW-1:0];
      wd_dl         = rd_dl_ff;
      wd_tag        = rd_tag_ff;
      push          = 1'b0;
      push_kind     = is_tick_ff ? RES_DUE : RES_FLUSHED;
      push_tag      = pend_tag_ff;
      push_last     = 1'b0;
      if (cmd.post) begin
         push      = 1'b1;
         push_kind = full ? RES_REJECTED : RES_ACCEPTED;
         push_tag  = req_task_tag;
         push_last = 1'b1;
         if (!full) begin
            we       = 1'b1;
            wa       = count_ff[AW-1:0];
            wd_dl    = post_dl;
            wd_tag   = req_task_tag;
            count_in = count_ff + CW'(1);
         end
      end
      if (cmd.start) begin
         is_tick_in    = req_kind == KIND_TICK;
         now_in        = req_now_ms;
         idx_in        = '0;
         keep_in       = '0;
         nres_in       = '0;
         pend_valid_in = 1'b0;
      end
      if (cmd.eval) begin
         idx_in = idx_ff + CW'(1);
         if (due) begin
            push          = pend_valid_ff;
            pend_tag_in   = rd_tag_ff;
            pend_valid_in = 1'b1;
            nres_in       = nres_ff + RES_CW'(1);
         end else begin
            we      = 1'b1;
            keep_in = keep_ff + CW'(1);
         end
      end
      if (cmd.final_push) begin
         push          = pend_valid_ff;
         push_last     = 1'b1;
         pend_valid_in = 1'b0;
         count_in      = keep_ff;
      end
      rsp_valid_in = push || (rsp_valid_ff && rsp_stall);
      rsp_kind_in  = push ? push_kind : rsp_kind_ff;
      rsp_tag_in   = push ? push_tag : rsp_tag_ff;
      rsp_last_in  = push ? push_last : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      keep_ff     <= keep_in;
      nres_ff     <= nres_in;
      is_tick_ff  <= is_tick_in;
      now_ff      <= now_in;
      pend_tag_ff <= pend_tag_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         dl_mem[wa]  <= wd_dl;
         tag_mem[wa] <= wd_tag;
      end
      if (cmd.read) begin
         rd_dl_ff  <= dl_mem[idx_ff[AW-1:0]];
         rd_tag_ff <= tag_mem[idx_ff[AW-1:0]];
      end
   end

   assign stat.scan_done  = idx_ff == count_ff;
   assign stat.due        = due;
   assign stat.pend_valid = pend_valid_ff;
   assign stat.out_free   = out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_task_tag_res = rsp_tag_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

[hw/rtl/deadline_task_table.sv]
// ----------------------------------------------------------------------------
// Deadline task table
// A bounded, insertion-ordered table of pending tasks with deadlines.
//
// The req channel carries one item per post, tick or stop. A post adds an
// entry with a saturated deadline if the table is not full, and answers with
// one accepted or rejected item in the cycle after it is taken. A tick scans
// every entry and answers with one item per due entry, oldest first; a stop
// answers with one item per entry and removes it. Each answers for at most
// MAX_RESULTS entries and keeps the rest. The last answer of a request has
// rsp_last set; a tick with nothing due, a stop on an empty table and the
// unused kind give no answer. A post is taken in the IDLE state. A tick or
// stop steps through READ and EVAL once per stored entry and then FINAL, set by
// the memory's single read port and the controller's read-evaluate loop.
// Reset empties the table and drops any pending answer. While the receiver
// stalls, the output register holds its item and the scan waits at the next
// due entry; no new request is taken until the output register can load.
// ----------------------------------------------------------------------------
`include "deadline_task_table_assert.svh"

module deadline_task_table import dtt_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_kind,
   input  logic [TIME_W-1:0] req_now_ms,
   input  logic [TIME_W-1:0] req_delay_ms,
   input  logic [TAG_W-1:0]  req_task_tag,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_result_kind,
   output logic [TAG_W-1:0]  rsp_task_tag_res,
   output logic              rsp_last
);

   cmd_type  cmd;
   stat_type stat;

   dtt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   dtt_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_kind         (req_kind),
      .req_now_ms       (req_now_ms),
      .req_delay_ms     (req_delay_ms),
      .req_task_tag     (req_task_tag),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_task_tag_res (rsp_task_tag_res),
      .rsp_last         (rsp_last)
   );

   `DTT_ASSERT_ALWAYS(a_cmd_onehot, clock, reset, $onehot0(cmd), "Commands overlap.")
   `DTT_ASSERT_IMPLY(a_eval_push_free, clock, reset, cmd.eval && stat.due && stat.pend_valid, stat.out_free, "Due entry pushed into a busy output register.")
   `DTT_ASSERT_IMPLY(a_final_push_free, clock, reset, cmd.final_push && stat.pend_valid, stat.out_free, "Last item pushed into a busy output register.")
   `DTT_ASSERT_IMPLY(a_post_answers, clock, reset, cmd.post, ##1 (rsp_valid && rsp_last), "Post did not answer.")

endmodule

[verif/tb_deadline_task_table.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deadline task table testbench
// Drives post, tick, stop and unused-kind items and checks every answer
// against a behavioral copy of the table, first from a short directed list
// and then from random sequences under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_deadline_task_table;
   import dtt_pkg::*;

   localparam int          TBL_DEPTH      = 16;
   localparam int          WATCHDOG_LIMIT = 3000;
   localparam logic [1:0]  KIND_UNUSED    = 2'd3;
   localparam logic [47:0] TIME_MAX       = {TIME_W{1'b1}};
   localparam int          N_ROWS         = 19;

   typedef enum logic [1:0] {
      CHECK_MODEL,
      CHECK_NONE,
      CHECK_ACCEPT,
      CHECK_REJECT
   } row_check_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [TAG_W-1:0] tag;
      logic             last;
   } result_item_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] delay;
      logic [TAG_W-1:0]  tag;
      logic [4:0]        reps;
      row_check_type     mode;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_kind = KIND_POST;
   logic [TIME_W-1:0] req_now_ms = '0;
   logic [TIME_W-1:0] req_delay_ms = '0;
   logic [TAG_W-1:0]  req_task_tag = '0;
   row_check_type     req_check_mode = CHECK_MODEL;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_result_kind;
   logic [TAG_W-1:0]  rsp_task_tag_res;
   logic              rsp_last;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int err_count = 0;
   int idle_cycles = 0;

   logic [TIME_W-1:0] model_deadline [TBL_DEPTH];
   logic [TAG_W-1:0]  model_tag [TBL_DEPTH];
   int                model_count = 0;
   logic [TIME_W-1:0] wall_ms = '0;
   result_item_type   awaited_results [$];

   stim_row_type directed_rows [N_ROWS] = '{
      '{KIND_STOP,   48'h0,           48'h0,    8'h00, 5'd1,  CHECK_NONE},
      '{KIND_TICK,   48'h0,           48'h0,    8'h00, 5'd1,  CHECK_NONE},
      '{KIND_UNUSED, TIME_MAX,        TIME_MAX, 8'hFF, 5'd1,  CHECK_NONE},
      '{KIND_POST,   48'h0,           48'h0,    8'h00, 5'd1,  CHECK_ACCEPT},
      '{KIND_POST,   TIME_MAX,        TIME_MAX, 8'hFF, 5'd1,  CHECK_ACCEPT},
      '{KIND_POST,   TIME_MAX,        48'h1,    8'hA5, 5'd1,  CHECK_ACCEPT},
      '{KIND_POST,   48'h1000,        48'h10,   8'h5A, 5'd1,  CHECK_ACCEPT},
      '{KIND_TICK,   48'h0,           48'h0,    8'h00, 5'd1,  CHECK_MODEL},
      '{KIND_TICK,   48'h100F,        48'h0,    8'h00, 5'd1,  CHECK_NONE},
      '{KIND_TICK,   48'h1010,        48'h0,    8'h00, 5'd1,  CHECK_MODEL},
      '{KIND_TICK,   TIME_MAX - 48'h1, 48'h0,   8'h00, 5'd1,  CHECK_NONE},
      '{KIND_TICK,   TIME_MAX,        48'h0,    8'h00, 5'd1,  CHECK_MODEL},
      '{KIND_POST,   48'h2000,        48'h0,    8'h10, 5'd16, CHECK_ACCEPT},
      '{KIND_POST,   48'h0,           48'h0,    8'hC3, 5'd1,  CHECK_REJECT},
      '{KIND_TICK,   48'h2007,        48'h0,    8'h00, 5'd1,  CHECK_MODEL},
      '{KIND_POST,   48'h2100,        48'h5,    8'h77, 5'd1,  CHECK_ACCEPT},
      '{KIND_TICK,   48'h2008,        48'h0,    8'h00, 5'd1,  CHECK_MODEL},
      '{KIND_STOP,   48'h0,           48'h0,    8'h00, 5'd1,  CHECK_MODEL},
      '{KIND_STOP,   48'h0,           48'h0,    8'h00, 5'd1,  CHECK_NONE}
   };

   deadline_task_table #(
      .DEPTH(TBL_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_now_ms(req_now_ms),
      .req_delay_ms(req_delay_ms),
      .req_task_tag(req_task_tag),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_task_tag_res(rsp_task_tag_res),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      if (err_count < 40) begin
         $display("ERROR at %0t: %s", $time, what);
      end
      err_count++;
   endtask

   function automatic void append_awaited(input result_item_type entry);
      awaited_results.insert(awaited_results.size(), entry);
   endfunction

   function automatic void predict_request(input logic [1:0] kind,
                                           input logic [TIME_W-1:0] now,
                                           input logic [TIME_W-1:0] delay,
                                           input logic [TAG_W-1:0] tag,
                                           input row_check_type mode);
      result_item_type batch [$];
      result_item_type item;
      logic [TIME_W:0] sum;
      int              keep;
      keep = 0;
      case (kind)
         KIND_POST: begin
            item.tag = tag;
            item.last = 1'b1;
            if (model_count >= TBL_DEPTH) begin
               item.kind = RES_REJECTED;
            end else begin
               sum = {1'b0, now} + {1'b0, delay};
               model_deadline[model_count] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
               model_tag[model_count] = tag;
               model_count++;
               item.kind = RES_ACCEPTED;
            end
            batch.insert(batch.size(), item);
         end
         KIND_TICK, KIND_STOP: begin
            for (int i = 0; i < model_count; i++) begin
               if ((kind == KIND_STOP || model_deadline[i] <= now)
                   && batch.size() < MAX_RESULTS) begin
                  item.kind = (kind == KIND_STOP) ? RES_FLUSHED : RES_DUE;
                  item.tag = model_tag[i];
                  item.last = 1'b0;
                  batch.insert(batch.size(), item);
               end else begin
                  model_deadline[keep] = model_deadline[i];
                  model_tag[keep] = model_tag[i];
                  keep++;
               end
            end
            model_count = keep;
         end
         default: ;
      endcase
      if (batch.size() > 0) begin
         batch[batch.size() - 1].last = 1'b1;
      end
      case (mode)
         CHECK_MODEL: begin
            foreach (batch[i]) append_awaited(batch[i]);
         end
         CHECK_ACCEPT: append_awaited('{RES_ACCEPTED, tag, 1'b1});
         CHECK_REJECT: append_awaited('{RES_REJECTED, tag, 1'b1});
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin : monitor
      result_item_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("unexpected item kind %0d tag %0h",
                                         rsp_result_kind, rsp_task_tag_res));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_result_kind !== want.kind)
                  report_mismatch($sformatf("result_kind %0d, expected %0d",
                                            rsp_result_kind, want.kind));
               if (rsp_task_tag_res !== want.tag)
                  report_mismatch($sformatf("task_tag_res %0h, expected %0h",
                                            rsp_task_tag_res, want.tag));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, expected %0b",
                                            rsp_last, want.last));
            end
         end
         if (req_valid && !req_stall) begin
            predict_request(req_kind, req_now_ms, req_delay_ms, req_task_tag,
                            req_check_mode);
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99, 0) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_deadline_task_table NOT OK");
         $finish;
      end
   end

   task automatic send_request(input logic [1:0] kind,
                               input logic [TIME_W-1:0] now,
                               input logic [TIME_W-1:0] delay,
                               input logic [TAG_W-1:0] tag,
                               input row_check_type mode);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_now_ms <= now;
      req_delay_ms <= delay;
      req_task_tag <= tag;
      req_check_mode <= mode;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
   endtask

   function automatic logic [TIME_W-1:0] rand_time();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[TIME_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] pick_delay();
      int r;
      r = $urandom_range(99, 0);
      if (r < 10) return '0;
      if (r < 80) return TIME_W'($urandom_range(800, 1));
      if (r < 92) return rand_time();
      return TIME_MAX - TIME_W'($urandom_range(3, 0));
   endfunction

   function automatic logic [TIME_W-1:0] pick_tick_now();
      int r;
      r = $urandom_range(99, 0);
      if (r < 85) begin
         wall_ms = wall_ms + TIME_W'($urandom_range(500, 0));
         return wall_ms;
      end
      if (r < 92) return rand_time();
      if (r < 96) begin
         wall_ms = rand_time() >> $urandom_range(8, 0);
         return wall_ms;
      end
      return TIME_MAX;
   endfunction

   task automatic run_random(input int target);
      int sent;
      int r;
      int burst;
      sent = 0;
      while (sent < target) begin
         r = $urandom_range(99, 0);
         if (r < 8) begin
            burst = $urandom_range(20, 12);
            repeat (burst) begin
               send_request(KIND_POST, wall_ms, TIME_W'($urandom_range(600, 0)),
                            TAG_W'($urandom), CHECK_MODEL);
               sent++;
            end
         end else if (r < 13) begin
            send_request(KIND_STOP, rand_time(), rand_time(), TAG_W'($urandom),
                         CHECK_MODEL);
            sent++;
         end else if (r < 17) begin
            send_request(KIND_UNUSED, rand_time(), rand_time(), TAG_W'($urandom),
                         CHECK_MODEL);
            sent++;
         end else if (r < 57) begin
            send_request(KIND_TICK, pick_tick_now(), rand_time(), TAG_W'($urandom),
                         CHECK_MODEL);
            sent++;
         end else begin
            send_request(KIND_POST,
                         ($urandom_range(99, 0) < 90) ? wall_ms : rand_time(),
                         pick_delay(), TAG_W'($urandom), CHECK_MODEL);
            sent++;
         end
         if ($urandom_range(99, 0) < 2) begin
            drain_results();
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 6;
      recv_stall_pct = 81;
      for (int r = 0; r < N_ROWS; r++) begin
         for (int i = 0; i < directed_rows[r].reps; i++) begin
            send_request(directed_rows[r].kind, directed_rows[r].now + TIME_W'(i),
                         directed_rows[r].delay, directed_rows[r].tag + TAG_W'(i),
                         directed_rows[r].mode);
         end
      end
      drain_results();
      run_random(105);

      drain_results();
      send_idle_pct = 81;
      recv_stall_pct = 6;
      run_random(105);

      drain_results();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      run_random(100);

      drain_results();
      repeat (60) @(posedge clock);
      if (err_count == 0) begin
         $display("tb_deadline_task_table OK");
      end else begin
         $display("tb_deadline_task_table NOT OK");
      end
      $finish;
   end

endmodule
